// ----- design/lru_page_cache_controller_unit_assert.svh -----
// Assertion macros for the LRU page cache controller top level.
`ifndef LRU_PAGE_CACHE_CONTROLLER_UNIT_ASSERT_SVH
`define LRU_PAGE_CACHE_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds too.
`define LPCC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpcc: implication check failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define LPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpcc: next-cycle check failed");
`else
`define LPCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/lpcc_pkg.sv -----
// Shared constants and controller/datapath interface types for the page cache.
package lpcc_pkg;

   localparam int SLOTS         = 16;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int COUNT_BITS    = $clog2(SLOTS + 1);
   localparam int PAGE_BITS     = 32;
   // hit, slot, fetch, write_back, write_back_page, write_back_slot
   localparam int RSP_FIELD_BITS = 1 + SLOT_BITS + 1 + 1 + PAGE_BITS + SLOT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic capture;     // latch the incoming page number
      logic lookup;      // run the tag match and update, emit one result
      logic flush_step;  // emit one write-back of the flush walk
   } cmd_type;

   typedef struct packed {
      logic                  out_free;    // output register can take a result
      logic                  flush_last;  // current flush step is the final one
      logic [COUNT_BITS-1:0] resident_count;
   } status_type;

endpackage

// ----- design/lru_page_cache_controller_unit.sv -----
// Top level of the fully associative LRU page cache controller.
//
// Requests arrive on the req_ channel: req_tuser carries the opcode (lookup or
// flush), req_tdata the page number. Each transaction is accepted when
// req_tvalid and req_tready are both high. A lookup returns one result; a
// flush returns one write-back per resident page, most recent first, or a
// single empty result when the cache is empty. rsp_tlast marks the final
// result of each request.
// A lookup is accepted in ST_IDLE; in ST_LOOKUP, once the output register is
// free, the parallel tag match and recency update run and the result is
// registered there. No new request is taken until that step has run.
// A flush is accepted, then walks the recency ranks in ST_FLUSH, one step
// per resident page (at least one), one rank per cycle while out_free holds.
// A new request is taken while a finished result still waits in the output
// register; when the receiver stalls, the block holds the pending result and
// stops before emitting the next one.
// Reset empties the cache at once (valid bits, ranks and count clear); no
// clearing pass is needed.
`include "lru_page_cache_controller_unit_assert.svh"

module lru_page_cache_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // requested_page [31:0]
   input  logic [lpcc_pkg::PAGE_BITS-1:0]       req_tdata,
   // opcode [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit [0], slot [4:1], fetch [5], write_back [6], write_back_page [38:7],
   // write_back_slot [42:39], zero pad [47:43]
   output logic [lpcc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);
   import lpcc_pkg::*;

   cmd_type    dp_cmd;
   status_type dp_status;

   // Sequence each transaction: capture, then lookup or flush walk.
   lpcc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // Tag store, ranks and the result register.
   lpcc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_page   (req_tdata),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // An accepted transaction always keeps the block busy for the next cycle.
   `LPCC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // A hit never asks the store to fetch.
   `LPCC_ASSERT_IMP(a_hit_no_fetch, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[5]))
   // A write-back always names the slot the result reports.
   `LPCC_ASSERT_IMP(a_wb_slot_match, clock, reset, rsp_tvalid && rsp_tdata[6], rsp_tdata[4:1] == rsp_tdata[42:39])
   // The resident count never exceeds the number of slots.
   `LPCC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, dp_status.resident_count <= COUNT_BITS'(SLOTS))

endmodule

// ----- design/lpcc_datapath.sv -----
// Page cache datapath: slot tags, recency ranks, tag match and result register.
module lpcc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [lpcc_pkg::PAGE_BITS-1:0]       req_page,
   input  lpcc_pkg::cmd_type                    cmd,
   output lpcc_pkg::status_type                 status,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [lpcc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);
   import lpcc_pkg::*;

   logic [PAGE_BITS-1:0]      page_q_ff;
   logic [SLOTS-1:0]          valid_ff, valid_in;
   logic [PAGE_BITS-1:0]      page_ff [SLOTS];
   logic [SLOT_BITS-1:0]      rank_ff [SLOTS];
   logic [SLOT_BITS-1:0]      rank_in [SLOTS];
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [SLOT_BITS-1:0]      flush_rank_ff, flush_rank_in;
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0]  out_data_ff, out_data_in;
   logic                      out_last_ff, out_last_in;

   logic [SLOTS-1:0]          match;
   logic                      hit, full, age_all, emit, out_free, flush_last;
   logic [SLOT_BITS-1:0]      hit_idx, free_idx, evict_idx, found_idx, tgt_idx, rd_idx;
   logic [SLOT_BITS-1:0]      tgt_rank;
   logic [PAGE_BITS-1:0]      rd_page;

   // Tag match, free-slot and victim search, flush walk search.
   always_comb begin
      match     = '0;
      hit_idx   = '0;
      free_idx  = '0;
      evict_idx = '0;
      found_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == page_q_ff)) begin
            match[i] = 1'b1;
            hit_idx  = SLOT_BITS'(i);
         end
         if (!valid_ff[i]) free_idx = SLOT_BITS'(i);
         if (valid_ff[i] && (rank_ff[i] == SLOT_BITS'(SLOTS - 1))) evict_idx = SLOT_BITS'(i);
         if (valid_ff[i] && (rank_ff[i] == flush_rank_ff)) found_idx = SLOT_BITS'(i);
      end
   end

   assign hit        = |match;
   assign full       = (count_ff == COUNT_BITS'(SLOTS));
   assign age_all    = !hit && !full;
   assign tgt_idx    = hit ? hit_idx : (full ? evict_idx : free_idx);
   assign tgt_rank   = rank_ff[tgt_idx];
   assign rd_idx     = cmd.flush_step ? found_idx : evict_idx;
   assign rd_page    = page_ff[rd_idx];
   assign flush_last = (count_ff == '0) ||
                       ((COUNT_BITS'(flush_rank_ff) + COUNT_BITS'(1)) == count_ff);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = cmd.lookup || cmd.flush_step;

   // Next state of the tag store and the result register.
   always_comb begin
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      count_in      = count_ff;
      flush_rank_in = flush_rank_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (cmd.lookup) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (valid_ff[i] && (age_all || (rank_ff[i] < tgt_rank)))
               rank_in[i] = rank_ff[i] + SLOT_BITS'(1);
         end
         rank_in[tgt_idx]  = '0;
         valid_in[tgt_idx] = 1'b1;
         if (age_all) count_in = count_ff + COUNT_BITS'(1);
         out_data_in = RSP_DATA_BITS'({
            (!hit && full) ? evict_idx : SLOT_BITS'(0),
            (!hit && full) ? rd_page   : PAGE_BITS'(0),
            !hit && full,
            !hit,
            tgt_idx,
            hit});
         out_last_in = 1'b1;
      end else if (cmd.flush_step) begin
         if (count_ff == '0) begin
            out_data_in = '0;
         end else begin
            out_data_in = RSP_DATA_BITS'({found_idx, rd_page, 1'b1, 1'b0, found_idx, 1'b0});
         end
         out_last_in = flush_last;
         if (flush_last) begin
            valid_in      = '0;
            count_in      = '0;
            flush_rank_in = '0;
            for (int i = 0; i < SLOTS; i++) rank_in[i] = '0;
         end else begin
            flush_rank_in = flush_rank_ff + SLOT_BITS'(1);
         end
      end
      if (emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         flush_rank_ff <= '0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < SLOTS; i++) rank_ff[i] <= '0;
      end else begin
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         flush_rank_ff <= flush_rank_in;
         out_valid_ff  <= out_valid_in;
         rank_ff       <= rank_in;
      end
   end

   // Payload: page number latch, tag store writes, result data.
   always_ff @(posedge clock) begin
      if (cmd.capture) page_q_ff <= req_page;
      if (cmd.lookup && !hit) page_ff[tgt_idx] <= page_q_ff;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign status.out_free       = out_free;
   assign status.flush_last     = flush_last;
   assign status.resident_count = count_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- design/lpcc_controller.sv -----
// Page cache controller: sequences capture, lookup and the flush walk.
module lpcc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_opcode,
   output logic                 req_tready,
   input  lpcc_pkg::status_type status,
   output lpcc_pkg::cmd_type    cmd
);
   import lpcc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_FLUSH  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_opcode == OP_FLUSH) ? ST_FLUSH : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.out_free) begin
               cmd.lookup = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_step = 1'b1;
               if (status.flush_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
